>>> rtl/s3tc_block_decoder_defines.svh
// ----------------------------------------------------------------------------
// S3TC block decoder assertion macros
// Shared property forms for the decoder checks; clock and reset are the
// top-level i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef S3TC_BLOCK_DECODER_DEFINES_SVH
`define S3TC_BLOCK_DECODER_DEFINES_SVH

// same-cycle implication
`define S3TC_ASSERT_NOW(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define S3TC_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/s3tc_pkg.sv
// ----------------------------------------------------------------------------
// S3TC decoder package
// Shared types, register indexes, expansion tables and the constant
// reciprocal dividers used by the block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package s3tc_pkg;

    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // configuration register indexes
    localparam int         CFG_DW     = 13;
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // alpha finishing operations
    localparam logic [1:0] AOP_PASS = 2'd0;
    localparam logic [1:0] AOP_DIV7 = 2'd1;
    localparam logic [1:0] AOP_DIV5 = 2'd2;

    // floor(x/3), floor(x/7), floor(x/5) by multiply and shift, exact over the ranges used
    localparam logic [9:0]  RECIP3 = 10'd683;   // >> 11, x < 2048
    localparam logic [11:0] RECIP7 = 12'd2341;  // >> 14, x < 5461
    localparam logic [10:0] RECIP5 = 11'd1639;  // >> 13, x < 2730

    // v * 255 / 31, truncated
    localparam logic [7:0] EXP5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // one queued block; color arrays: [2] red, [1] green, [0] blue
    typedef struct packed {
        logic [2:0][7:0] e0;
        logic [2:0][7:0] e1;
        logic            four;
        logic            dxt5;
        logic [31:0]     csel;
        logic [7:0]      a0;
        logic [7:0]      a1;
        logic [47:0]     asel;
        logic [9:0]      bx;
        logic [9:0]      by;
        logic [1:0]      ncl;   // last in-image column within the block
        logic [1:0]      nrl;   // last in-image row within the block
        logic            ilast;
    } t_blk;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return EXP5_LUT[v];
    endfunction

    // v * 255 / 63 = 4v + floor(v / 21)
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] f;
        if (v == 6'd63) begin
            f = 2'd3;
        end else if (v >= 6'd42) begin
            f = 2'd2;
        end else if (v >= 6'd21) begin
            f = 2'd1;
        end else begin
            f = 2'd0;
        end
        return {v, 2'b00} + {6'b0, f};
    endfunction

    function automatic logic [7:0] div3_u10(input logic [9:0] x);
        logic [19:0] p;
        p = {10'b0, x} * {10'b0, RECIP3};
        return p[18:11];
    endfunction

    function automatic logic [7:0] div7_u11(input logic [10:0] x);
        logic [22:0] p;
        p = {12'b0, x} * {11'b0, RECIP7};
        return p[21:14];
    endfunction

    function automatic logic [7:0] div5_u11(input logic [10:0] x);
        logic [21:0] p;
        p = {11'b0, x} * {11'b0, RECIP5};
        return p[20:13];
    endfunction

endpackage

`default_nettype wire

>>> rtl/s3tc_front.sv
// ----------------------------------------------------------------------------
// S3TC front end
// Holds the configuration and block position counters, accepts compressed
// blocks, expands endpoints and works out the clipping of each block.
// ----------------------------------------------------------------------------
`default_nettype none

module s3tc_front
    import s3tc_pkg::*;
#(
    parameter int MAX_SIDE = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [15:0]       i_color_end0,
    input  logic [15:0]       i_color_end1,
    input  logic [31:0]       i_color_select,
    input  logic [7:0]        i_alpha_end0,
    input  logic [7:0]        i_alpha_end1,
    input  logic [47:0]       i_alpha_select,
    input  t_q_stat           i_q_stat,
    output logic              o_q_wr_en,
    output t_blk              o_q_wr_data
);

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int CW = SW - 1;

    function automatic logic [SW-1:0] clamp_side(input logic [CFG_DW-1:0] v);
        if (v == '0) begin
            return SW'(1);
        end else if (32'(v) > MAX_SIDE) begin
            return SW'(MAX_SIDE);
        end
        return SW'(v);
    endfunction

    function automatic logic [CW-1:0] side_blocks(input logic [SW-1:0] s);
        logic [SW:0] t;
        t = {1'b0, s} + (SW+1)'(3);
        return t[SW:2];
    endfunction

    logic          r_fmt;
    logic [SW-1:0] r_w;
    logic [SW-1:0] r_h;
    logic [CW-1:0] r_cols;
    logic [CW-1:0] r_rows;
    logic [CW-1:0] r_bcol;
    logic [CW-1:0] r_brow;

    logic [SW-1:0] cfg_side;
    logic          wr_w;
    logic          wr_h;
    logic          accept;
    logic [CW-1:0] cur_col;
    logic [CW-1:0] cur_row;
    logic [CW-1:0] col_inc;
    logic [CW-1:0] row_inc;
    logic [SW:0]   rem_x;
    logic [SW:0]   rem_y;
    logic          last_blk;
    logic [CW-1:0] n_bcol;
    logic [CW-1:0] n_brow;

    assign cfg_side   = clamp_side(i_cfg_data);
    assign wr_w       = i_cfg_wr_en && (i_cfg_index == CFG_WIDTH);
    assign wr_h       = i_cfg_wr_en && (i_cfg_index == CFG_HEIGHT);
    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;
    assign o_q_wr_en  = accept;

    always_comb begin
        if (r_bcol >= r_cols || r_brow >= r_rows) begin
            cur_col = '0;
            cur_row = '0;
        end else begin
            cur_col = r_bcol;
            cur_row = r_brow;
        end
        col_inc  = cur_col + CW'(1);
        row_inc  = cur_row + CW'(1);
        last_blk = (col_inc == r_cols) && (row_inc == r_rows);
        rem_x    = {1'b0, r_w} - {cur_col, 2'b00};
        rem_y    = {1'b0, r_h} - {cur_row, 2'b00};

        n_bcol = r_bcol;
        n_brow = r_brow;
        if (wr_w || wr_h) begin
            n_bcol = '0;
            n_brow = '0;
        end else if (accept) begin
            if (col_inc >= r_cols) begin
                n_bcol = '0;
                n_brow = (row_inc >= r_rows) ? '0 : row_inc;
            end else begin
                n_bcol = col_inc;
                n_brow = cur_row;
            end
        end
    end

    always_comb begin
        o_q_wr_data.e0    = {expand5(i_color_end0[15:11]), expand6(i_color_end0[10:5]),
                             expand5(i_color_end0[4:0])};
        o_q_wr_data.e1    = {expand5(i_color_end1[15:11]), expand6(i_color_end1[10:5]),
                             expand5(i_color_end1[4:0])};
        o_q_wr_data.four  = r_fmt || (i_color_end0 > i_color_end1);
        o_q_wr_data.dxt5  = r_fmt;
        o_q_wr_data.csel  = i_color_select;
        o_q_wr_data.a0    = i_alpha_end0;
        o_q_wr_data.a1    = i_alpha_end1;
        o_q_wr_data.asel  = i_alpha_select;
        o_q_wr_data.bx    = 10'(cur_col);
        o_q_wr_data.by    = 10'(cur_row);
        o_q_wr_data.ncl   = (rem_x >= (SW+1)'(4)) ? 2'd3 : (rem_x[1:0] - 2'd1);
        o_q_wr_data.nrl   = (rem_y >= (SW+1)'(4)) ? 2'd3 : (rem_y[1:0] - 2'd1);
        o_q_wr_data.ilast = last_blk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= 1'b0;
            r_w    <= SW'(4);
            r_h    <= SW'(4);
            r_cols <= CW'(1);
            r_rows <= CW'(1);
            r_bcol <= '0;
            r_brow <= '0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index == CFG_FORMAT)) begin
                r_fmt <= i_cfg_data[0];
            end
            if (wr_w) begin
                r_w    <= cfg_side;
                r_cols <= side_blocks(cfg_side);
            end
            if (wr_h) begin
                r_h    <= cfg_side;
                r_rows <= side_blocks(cfg_side);
            end
            r_bcol <= n_bcol;
            r_brow <= n_brow;
        end
    end

endmodule

`default_nettype wire

>>> rtl/s3tc_queue.sv
// ----------------------------------------------------------------------------
// S3TC block queue
// Short FIFO of classified blocks between the front end and the pixel
// back end; the head entry is the block being expanded.
// ----------------------------------------------------------------------------
`default_nettype none

module s3tc_queue
    import s3tc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_en,
    input  t_blk    i_wr_data,
    input  logic    i_pop,
    output t_blk    o_head,
    output t_q_stat o_stat
);

    t_blk           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_cnt;

    logic [QAW:0]   n_cnt;

    function automatic logic [QAW-1:0] ptr_next(input logic [QAW-1:0] p);
        return (p == QAW'(QDEPTH - 1)) ? '0 : (p + QAW'(1));
    endfunction

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr_en && !i_pop) begin
            n_cnt = r_cnt + (QAW+1)'(1);
        end else if (!i_wr_en && i_pop) begin
            n_cnt = r_cnt - (QAW+1)'(1);
        end
    end

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_next(r_rptr);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> rtl/s3tc_back.sv
// ----------------------------------------------------------------------------
// S3TC pixel back end
// Walks the in-image pixels of the head block, one per cycle while the
// output is not stalled: the first stage picks the indices and forms
// palette sums, the second finishes the divisions into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module s3tc_back
    import s3tc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_blk        i_head,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_pixel_x,
    output logic [11:0] o_pixel_y,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_block_last,
    output logic        o_image_last
);

    // pixel walk
    logic [1:0] r_pc;
    logic [1:0] r_pr;

    // stage 1
    logic            r_s1_v;
    logic [2:0][9:0] r_s1_num;
    logic            r_s1_cdiv3;
    logic [10:0]     r_s1_anum;
    logic [1:0]      r_s1_aop;
    logic [11:0]     r_s1_x;
    logic [11:0]     r_s1_y;
    logic            r_s1_blast;
    logic            r_s1_ilast;

    // output register
    logic            r_o_v;
    logic [2:0][7:0] r_o_rgb;
    logic [7:0]      r_o_a;
    logic [11:0]     r_o_x;
    logic [11:0]     r_o_y;
    logic            r_o_blast;
    logic            r_o_ilast;

    logic            out_ready;
    logic            s1_move;
    logic            s1_ready;
    logic            issue;
    logic            pix_last;
    logic [3:0]      pidx;
    logic [1:0]      ci;
    logic [2:0]      ai;
    logic [2:0][9:0] n_num;
    logic [10:0]     n_anum;
    logic [1:0]      n_aop;
    logic [3:0]      wa7;
    logic [3:0]      wa5;
    logic [3:0]      wb;
    logic [11:0]     sum7;
    logic [11:0]     sum5;
    logic [2:0][7:0] n_rgb;
    logic [7:0]      n_a;

    assign out_ready = !r_o_v || !i_out_stall;
    assign s1_move   = r_s1_v && out_ready;
    assign s1_ready  = !r_s1_v || out_ready;
    assign issue     = !i_q_stat.empty && s1_ready;
    assign pix_last  = (r_pc == i_head.ncl) && (r_pr == i_head.nrl);
    assign o_pop     = issue && pix_last;

    assign pidx = {r_pr, r_pc};
    assign ci   = i_head.csel[{pidx, 1'b0} +: 2];
    assign ai   = i_head.asel[6'(pidx) * 6'd3 +: 3];

    // color: endpoints, 2:1 / 1:2 mixes, or in three-color mode the midpoint and black
    always_comb begin
        logic [9:0] s_mid;
        logic [9:0] s_2a;
        logic [9:0] s_2b;
        for (int k = 0; k < 3; k++) begin
            s_mid = {2'b0, i_head.e0[k]} + {2'b0, i_head.e1[k]};
            s_2a  = {1'b0, i_head.e0[k], 1'b0} + {2'b0, i_head.e1[k]};
            s_2b  = {2'b0, i_head.e0[k]} + {1'b0, i_head.e1[k], 1'b0};
            case (ci)
                2'd0:    n_num[k] = {2'b0, i_head.e0[k]};
                2'd1:    n_num[k] = {2'b0, i_head.e1[k]};
                2'd2:    n_num[k] = i_head.four ? s_2a : {1'b0, s_mid[9:1]};
                2'd3:    n_num[k] = i_head.four ? s_2b : '0;
                default: n_num[k] = '0;
            endcase
        end
    end

    // alpha: weights only matter for indexes 2..7
    always_comb begin
        wa7  = 4'd8 - {1'b0, ai};
        wa5  = 4'd6 - {1'b0, ai};
        wb   = {1'b0, ai} - 4'd1;
        sum7 = 12'(wa7) * {4'b0, i_head.a0} + 12'(wb) * {4'b0, i_head.a1};
        sum5 = 12'(wa5) * {4'b0, i_head.a0} + 12'(wb) * {4'b0, i_head.a1};
        n_aop = AOP_PASS;
        if (!i_head.dxt5) begin
            n_anum = (i_head.four || (ci != 2'd3)) ? 11'd255 : 11'd0;
        end else if (ai == 3'd0) begin
            n_anum = {3'b0, i_head.a0};
        end else if (ai == 3'd1) begin
            n_anum = {3'b0, i_head.a1};
        end else if (i_head.a0 > i_head.a1) begin
            n_anum = sum7[10:0];
            n_aop  = AOP_DIV7;
        end else if (ai == 3'd6) begin
            n_anum = 11'd0;
        end else if (ai == 3'd7) begin
            n_anum = 11'd255;
        end else begin
            n_anum = sum5[10:0];
            n_aop  = AOP_DIV5;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_rgb[k] = r_s1_cdiv3 ? div3_u10(r_s1_num[k]) : r_s1_num[k][7:0];
        end
        case (r_s1_aop)
            AOP_DIV7: n_a = div7_u11(r_s1_anum);
            AOP_DIV5: n_a = div5_u11(r_s1_anum);
            default:  n_a = r_s1_anum[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_pr   <= '0;
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (issue) begin
                if (pix_last) begin
                    r_pc <= '0;
                    r_pr <= '0;
                end else if (r_pc == i_head.ncl) begin
                    r_pc <= '0;
                    r_pr <= r_pr + 2'd1;
                end else begin
                    r_pc <= r_pc + 2'd1;
                end
            end
            if (s1_ready) begin
                r_s1_v <= issue;
            end
            if (out_ready) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_num   <= n_num;
            r_s1_cdiv3 <= i_head.four && ci[1];
            r_s1_anum  <= n_anum;
            r_s1_aop   <= n_aop;
            r_s1_x     <= {i_head.bx, r_pc};
            r_s1_y     <= {i_head.by, r_pr};
            r_s1_blast <= pix_last;
            r_s1_ilast <= pix_last && i_head.ilast;
        end
        if (s1_move) begin
            r_o_rgb   <= n_rgb;
            r_o_a     <= n_a;
            r_o_x     <= r_s1_x;
            r_o_y     <= r_s1_y;
            r_o_blast <= r_s1_blast;
            r_o_ilast <= r_s1_ilast;
        end
    end

    assign o_out_valid  = r_o_v;
    assign o_pixel_x    = r_o_x;
    assign o_pixel_y    = r_o_y;
    assign o_red        = r_o_rgb[2];
    assign o_green      = r_o_rgb[1];
    assign o_blue       = r_o_rgb[0];
    assign o_alpha      = r_o_a;
    assign o_block_last = r_o_blast;
    assign o_image_last = r_o_ilast;

endmodule

`default_nettype wire

>>> rtl/s3tc_block_decoder.sv
// ----------------------------------------------------------------------------
// S3TC block decoder (DXT1 / DXT5)
// Input channel: one compressed 4x4 block per request, in raster block order.
// Output channel: one RGBA pixel per request with its image position, in
// raster order inside the block; pixels outside the image are dropped.
// block_last marks the final pixel of a block, image_last that of the image.
// Registers (format, width, height) are written through the plain write port;
// a size write restarts at the top-left block.
// The first pixel of a block passes through the block queue, the stage-1
// register and the output register. The single pixel pipeline in the back
// end gives one pixel per cycle while the output is not stalled.
// A two-entry block queue lets new blocks be taken while pixels are stalled.
// Reset empties the queue and pipeline and returns the registers to DXT1,
// 4x4. A stall holds the output pixel; the pipeline then backs up into the
// queue and the input stall rises once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "s3tc_block_decoder_defines.svh"

module s3tc_block_decoder
    import s3tc_pkg::*;
#(
    parameter int MAX_SIDE = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [15:0]       i_color_end0,
    input  logic [15:0]       i_color_end1,
    input  logic [31:0]       i_color_select,
    input  logic [7:0]        i_alpha_end0,
    input  logic [7:0]        i_alpha_end1,
    input  logic [47:0]       i_alpha_select,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [11:0]       o_pixel_x,
    output logic [11:0]       o_pixel_y,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [7:0]        o_alpha,
    output logic              o_block_last,
    output logic              o_image_last
);

    logic    q_wr_en;
    t_blk    q_wr_data;
    t_blk    q_head;
    t_q_stat q_stat;
    logic    q_pop;

    s3tc_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_color_end0   (i_color_end0),
        .i_color_end1   (i_color_end1),
        .i_color_select (i_color_select),
        .i_alpha_end0   (i_alpha_end0),
        .i_alpha_end1   (i_alpha_end1),
        .i_alpha_select (i_alpha_select),
        .i_q_stat       (q_stat),
        .o_q_wr_en      (q_wr_en),
        .o_q_wr_data    (q_wr_data)
    );

    s3tc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr_en),
        .i_wr_data (q_wr_data),
        .i_pop     (q_pop),
        .o_head    (q_head),
        .o_stat    (q_stat)
    );

    s3tc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_q_stat     (q_stat),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_block_last (o_block_last),
        .o_image_last (o_image_last)
    );

    // image end is always also a block end
    `S3TC_ASSERT_NOW(a_ilast_blast, o_out_valid && o_image_last, o_block_last, "image_last without block_last")

    // pixels of one block follow each other without a gap
    `S3TC_ASSERT_NEXT(a_block_burst, o_out_valid && !i_out_stall && !o_block_last, o_out_valid, "gap inside a block")

    // the pixel after a block end is the top-left pixel of the next block
    `S3TC_ASSERT_NEXT(a_next_block_origin, o_out_valid && !i_out_stall && o_block_last, !o_out_valid || (o_pixel_x[1:0] == 2'b00 && o_pixel_y[1:0] == 2'b00), "new block not at its origin")

    // the queue never reports full and empty at once
    `S3TC_ASSERT_NOW(a_queue_state, q_stat.full, !q_stat.empty, "queue full and empty")

endmodule

`default_nettype wire

>>> tb/s3tc_block_decoder_tb.sv
// ----------------------------------------------------------------------------
// S3TC block decoder testbench
// Feeds compressed 4x4 blocks through the valid/stall input channel and checks
// every decoded pixel (position, RGBA, block and image end flags) against a
// behavioral decoder kept in the bench. Runs DXT1 and DXT5 over several image
// sizes, including clamped ones, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module s3tc_block_decoder_tb;
    import s3tc_pkg::*;

    localparam int             SIDE_MAX   = 4096;
    localparam int             IDLE_LIMIT = 4000;
    localparam logic [1:0]     CFG_SPARE  = 2'd3;   // unused index, must be ignored

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [15:0] color_end0;
        logic [15:0] color_end1;
        logic [31:0] color_select;
        logic [7:0]  alpha_end0;
        logic [7:0]  alpha_end1;
        logic [47:0] alpha_select;
    } block_req_t;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        block_last;
        logic        image_last;
    } pixel_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [1:0]        i_cfg_index = CFG_FORMAT;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [15:0]       i_color_end0 = '0;
    logic [15:0]       i_color_end1 = '0;
    logic [31:0]       i_color_select = '0;
    logic [7:0]        i_alpha_end0 = '0;
    logic [7:0]        i_alpha_end1 = '0;
    logic [47:0]       i_alpha_select = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [11:0]       o_pixel_x;
    logic [11:0]       o_pixel_y;
    logic [7:0]        o_red;
    logic [7:0]        o_green;
    logic [7:0]        o_blue;
    logic [7:0]        o_alpha;
    logic              o_block_last;
    logic              o_image_last;

    s3tc_block_decoder #(.MAX_SIDE(SIDE_MAX)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_color_end0   (i_color_end0),
        .i_color_end1   (i_color_end1),
        .i_color_select (i_color_select),
        .i_alpha_end0   (i_alpha_end0),
        .i_alpha_end1   (i_alpha_end1),
        .i_alpha_select (i_alpha_select),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_block_last   (o_block_last),
        .o_image_last   (o_image_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // bench copy of the decoder state
    logic              fmt_dxt5;
    logic [12:0]       reg_width;
    logic [12:0]       reg_height;
    int                blk_col;
    int                blk_row;

    block_req_t        block_q [$];   // blocks waiting to be driven
    pixel_t            pixel_q [$];   // decoded pixels still to arrive

    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    logic              in_took = 1'b0;
    int                errors = 0;
    int                blocks_in = 0;
    int                pixels_seen = 0;
    int                images_done = 0;
    int                idle_cycles = 0;

    function automatic int side_clamp(input logic [12:0] v);
        if (v == 13'd0) return 1;
        if (int'(v) > SIDE_MAX) return SIDE_MAX;
        return int'(v);
    endfunction

    function automatic logic [7:0] alpha_level(input logic [7:0] a0, input logic [7:0] a1,
                                               input logic [2:0] idx);
        int lo;
        int hi;
        int i;
        lo = a0;
        hi = a1;
        i  = idx;
        if (i == 0) return a0;
        if (i == 1) return a1;
        if (lo > hi) return 8'(((8 - i) * lo + (i - 1) * hi) / 7);
        if (i == 6) return 8'd0;
        if (i == 7) return 8'd255;
        return 8'(((6 - i) * lo + (i - 1) * hi) / 5);
    endfunction

    // decode one block into pixel_q and advance the block position
    task automatic decode_block(input block_req_t b);
        int w, h, cols, rows, x, y, last_x, last_y, last_p;
        int e0 [3];
        int e1 [3];
        int pal [4][4];
        logic four, last_blk;
        logic [1:0] ci;
        pixel_t px;
        w    = side_clamp(reg_width);
        h    = side_clamp(reg_height);
        cols = (w + 3) / 4;
        rows = (h + 3) / 4;
        if (blk_col >= cols || blk_row >= rows) begin
            blk_col = 0;
            blk_row = 0;
        end
        last_blk = (blk_col == cols - 1) && (blk_row == rows - 1);
        four = fmt_dxt5 || (b.color_end0 > b.color_end1);

        e0[0] = int'(b.color_end0[15:11]) * 255 / 31;
        e0[1] = int'(b.color_end0[10:5]) * 255 / 63;
        e0[2] = int'(b.color_end0[4:0]) * 255 / 31;
        e1[0] = int'(b.color_end1[15:11]) * 255 / 31;
        e1[1] = int'(b.color_end1[10:5]) * 255 / 63;
        e1[2] = int'(b.color_end1[4:0]) * 255 / 31;
        for (int k = 0; k < 3; k++) begin
            pal[0][k] = e0[k];
            pal[1][k] = e1[k];
            if (four) begin
                pal[2][k] = (2 * e0[k] + e1[k]) / 3;
                pal[3][k] = (e0[k] + 2 * e1[k]) / 3;
            end else begin
                pal[2][k] = (e0[k] + e1[k]) / 2;
                pal[3][k] = 0;
            end
        end
        pal[0][3] = 255;
        pal[1][3] = 255;
        pal[2][3] = 255;
        pal[3][3] = four ? 255 : 0;

        // last in-image pixel of this block
        last_x = (w - 1 - blk_col * 4 > 3) ? 3 : w - 1 - blk_col * 4;
        last_y = (h - 1 - blk_row * 4 > 3) ? 3 : h - 1 - blk_row * 4;
        last_p = last_y * 4 + last_x;

        for (int p = 0; p < 16; p++) begin
            x = blk_col * 4 + (p % 4);
            y = blk_row * 4 + (p / 4);
            if (x < w && y < h) begin
                ci = b.color_select[2 * p +: 2];
                px.x = x[11:0];
                px.y = y[11:0];
                px.red   = 8'(pal[ci][0]);
                px.green = 8'(pal[ci][1]);
                px.blue  = 8'(pal[ci][2]);
                px.alpha = fmt_dxt5 ? alpha_level(b.alpha_end0, b.alpha_end1,
                                                  b.alpha_select[3 * p +: 3])
                                    : 8'(pal[ci][3]);
                px.block_last = (p == last_p);
                px.image_last = (p == last_p) && last_blk;
                pixel_q.push_back(px);
            end
        end

        blk_col++;
        if (blk_col >= cols) begin
            blk_col = 0;
            blk_row++;
            if (blk_row >= rows) blk_row = 0;
        end
    endtask

    function automatic int field_bad(input string name, input logic [11:0] want,
                                     input logic [11:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        pixel_t want;
        int bad;
        in_took = 1'b0;
        if (!i_rst_n) begin
            fmt_dxt5   = 1'b0;
            reg_width  = 13'd4;
            reg_height = 13'd4;
            blk_col    = 0;
            blk_row    = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FORMAT: fmt_dxt5 = i_cfg_data[0];
                    CFG_WIDTH: begin
                        reg_width = i_cfg_data;
                        blk_col = 0;
                        blk_row = 0;
                    end
                    CFG_HEIGHT: begin
                        reg_height = i_cfg_data;
                        blk_col = 0;
                        blk_row = 0;
                    end
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                pixels_seen++;
                if (o_image_last) images_done++;
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected pixel x=%0d y=%0d", $time, o_pixel_x, o_pixel_y);
                    errors++;
                end else begin
                    want = pixel_q.pop_front();
                    bad = 0;
                    bad += field_bad("pixel_x", want.x, o_pixel_x);
                    bad += field_bad("pixel_y", want.y, o_pixel_y);
                    bad += field_bad("red", 12'(want.red), 12'(o_red));
                    bad += field_bad("green", 12'(want.green), 12'(o_green));
                    bad += field_bad("blue", 12'(want.blue), 12'(o_blue));
                    bad += field_bad("alpha", 12'(want.alpha), 12'(o_alpha));
                    bad += field_bad("block_last", 12'(want.block_last), 12'(o_block_last));
                    bad += field_bad("image_last", 12'(want.image_last), 12'(o_image_last));
                    if (bad != 0) errors++;
                end
            end
            // pixels of a block never leave in the cycle the block is taken
            if (i_in_valid && !o_in_stall) begin
                decode_block('{i_color_end0, i_color_end1, i_color_select,
                               i_alpha_end0, i_alpha_end1, i_alpha_select});
                blocks_in++;
                in_took = 1'b1;
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d pixels outstanding",
                         $time, IDLE_LIMIT, pixel_q.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // request driver and receiver stall
    always @(negedge i_clk) begin
        block_req_t b;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_took) begin
                if (block_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    b = block_q.pop_front();
                    i_color_end0   <= b.color_end0;
                    i_color_end1   <= b.color_end1;
                    i_color_select <= b.color_select;
                    i_alpha_end0   <= b.alpha_end0;
                    i_alpha_end1   <= b.alpha_end1;
                    i_alpha_select <= b.alpha_select;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic block_req_t mk_block(input logic [15:0] c0, input logic [15:0] c1,
                                            input logic [31:0] csel, input logic [7:0] a0,
                                            input logic [7:0] a1, input logic [47:0] asel);
        block_req_t b;
        b.color_end0   = c0;
        b.color_end1   = c1;
        b.color_select = csel;
        b.alpha_end0   = a0;
        b.alpha_end1   = a1;
        b.alpha_select = asel;
        return b;
    endfunction

    function automatic block_req_t rand_block();
        block_req_t b;
        b.color_end0   = 16'($urandom);
        b.color_end1   = ($urandom_range(0, 7) == 0) ? b.color_end0 : 16'($urandom);
        b.color_select = $urandom;
        b.alpha_end0   = 8'($urandom);
        b.alpha_end1   = ($urandom_range(0, 7) == 0) ? b.alpha_end0 : 8'($urandom);
        b.alpha_select = {16'($urandom), 32'($urandom)};
        return b;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default:   begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    // sender holds off until every pending block is decoded and every pixel is back
    task automatic drain();
        while (block_q.size() != 0 || i_in_valid || pixel_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int fmt, w, h;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: DXT1, one-block 4x4 image
        set_idle(IDLE_NONE);
        block_q.push_back(mk_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4, 8'hFF, 8'hFF, '1));
        block_q.push_back(mk_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4, 8'h00, 8'hFF, '0));
        block_q.push_back(mk_block(16'h7BEF, 16'h7BEF, 32'hFFFFFFFF, 8'h12, 8'h34, '1));
        block_q.push_back(mk_block(16'hF800, 16'h07E0, 32'h00000000, 8'h00, 8'h00, '0));
        block_q.push_back(mk_block(16'h001F, 16'hF81F, 32'h1B1B1B1B, 8'hAA, 8'h55, '1));
        block_q.push_back(mk_block(16'h8410, 16'h8411, 32'h55555555, 8'h00, 8'h00, '0));
        drain();

        // DXT5: four colors regardless of endpoint order, both alpha palettes
        write_reg(CFG_FORMAT, 13'h1FFF);
        block_q.push_back(mk_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4, 8'd255, 8'd0,
                                   48'o7654321076543210));
        block_q.push_back(mk_block(16'hFFFF, 16'h0000, 32'h1B1B1B1B, 8'd0, 8'd255,
                                   48'o7654321076543210));
        block_q.push_back(mk_block(16'h1234, 16'h5678, 32'hAAAAAAAA, 8'd128, 8'd128,
                                   48'o0123456701234567));
        block_q.push_back(mk_block(16'hABCD, 16'h4321, 32'hFFFFFFFF, 8'd200, 8'd13, '1));
        block_q.push_back(mk_block(16'h07E0, 16'hF81F, 32'h00000000, 8'd7, 8'd250, '0));
        block_q.push_back(mk_block(16'hFFFF, 16'hFFFF, 32'hE4E4E4E4, 8'd1, 8'd2,
                                   48'o7654321076543210));
        drain();

        // zero sizes are taken as 1x1
        write_reg(CFG_WIDTH, 13'd0);
        write_reg(CFG_HEIGHT, 13'd0);
        block_q.push_back(rand_block());
        block_q.push_back(rand_block());
        drain();

        // 5x7 clips right and bottom blocks; fifth block wraps into a new image
        write_reg(CFG_FORMAT, 13'h1FFE);
        write_reg(CFG_WIDTH, 13'd5);
        write_reg(CFG_HEIGHT, 13'd7);
        for (int i = 0; i < 5; i++) block_q.push_back(rand_block());
        drain();
        // spare index is ignored, then a size write mid-image restarts top-left
        write_reg(CFG_SPARE, 13'($urandom));
        write_reg(CFG_WIDTH, 13'd5);
        for (int i = 0; i < 2; i++) block_q.push_back(rand_block());
        drain();

        // oversized width clamps to the maximum side
        write_reg(CFG_WIDTH, 13'h1FFF);
        write_reg(CFG_HEIGHT, 13'd1);
        block_q.push_back(rand_block());
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            fmt = (ph % 3 == 1) ? 1 : 0;
            case (ph)
                3:       begin w = 4096; h = 5;    end
                6:       begin w = 8191; h = 4097; end
                8:       begin w = 4097; h = 0;    end
                default: begin w = $urandom_range(1, 24); h = $urandom_range(1, 24); end
            endcase
            write_reg(CFG_FORMAT, {12'($urandom), fmt[0]});
            write_reg(CFG_WIDTH, 13'(w));
            write_reg(CFG_HEIGHT, 13'(h));
            set_idle(idle_mode_t'(ph % 4));
            for (int i = 0; i < 35; i++) block_q.push_back(rand_block());
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("covered %0d blocks and %0d pixels over DXT1 and DXT5, %0d image ends,",
                 blocks_in, pixels_seen, images_done);
        $display("sizes from 1x1 to clamped 4096x4096 with sender gaps and receiver stalls");
        if (errors == 0 && pixel_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d pixels never arrived", errors, pixel_q.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/s3tc_pkg.sv
rtl/s3tc_front.sv
rtl/s3tc_queue.sv
rtl/s3tc_back.sv
rtl/s3tc_block_decoder.sv
tb/s3tc_block_decoder_tb.sv
